[hw/rtl/wtroc_pkg.sv]
// Shared types and constants for the weighted triple-EMA rate-of-change block.
// Used by wtroc_smul, wtroc_sdiv, weighted_triple_ema_rate_of_change and the bench.
// No dependencies.
package wtroc_pkg;

    // Field widths
    localparam int PRICE_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int EMA_W    = 48;
    localparam int EXTRA_W  = 16;
    localparam int COUNT_W  = 13;
    localparam int SEED_W   = 13;
    localparam int K_W      = 16;
    localparam int ALPHA_W  = 16;
    localparam int RES_W    = 32;
    localparam int S_DATA_W = 48;   // price + weight, already whole bytes

    // Serial multiplier: multiplicand, multiplier, product
    localparam int MA_W = 49;
    localparam int MB_W = 17;
    localparam int MP_W = MA_W + MB_W;

    // Serial divider: dividend bits shifted in, remainder/divisor width
    localparam int DV_W = 64;
    localparam int DR_W = 49;

    // Config port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0]  COUNT_LIMIT = 13'd8191;
    localparam logic [MB_W-1:0]     SCALE_CONST = 17'd100000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 16'd32768;
    localparam logic [SEED_W-1:0]   SEED_RESET  = 13'd14;
    localparam logic [K_W-1:0]      K_RESET     = 16'd8738;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED_LENGTH = 8'd0,
        REG_SMOOTHING   = 8'd1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_MWAIT,
        ST_SEED_SUM,
        ST_SEED_DIV,
        ST_SEED_DWAIT,
        ST_ALPHA_MUL,
        ST_ALPHA_WAIT,
        ST_EMA_DIFF,
        ST_EMA_MUL,
        ST_EMA_WAIT,
        ST_EMA_RND,
        ST_EMA_UPD,
        ST_ROC_DIFF,
        ST_ROC_MUL,
        ST_ROC_MWAIT,
        ST_ROC_DIV,
        ST_ROC_DWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic over;
    } div_stat_t;

endpackage

[hw/rtl/wtroc_smul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on wtroc_pkg.
module wtroc_smul import wtroc_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [MA_W-1:0] a,
    input  logic [MB_W-1:0] b,
    output mul_stat_t       stat,
    output logic [MP_W-1:0] prod
);

    localparam int CNT_W = $clog2(MB_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MA_W-1:0]  a_reg;
    logic [MA_W-1:0]  hi_reg;
    logic [MB_W-1:0]  lo_reg;
    logic [MA_W:0]    sum;
    logic             last;

    assign sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
    assign last = (cnt_reg == CNT_W'(MB_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // accumulate, then shift the pair right by one
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end else if (busy_reg) begin
            hi_reg <= sum[MA_W:1];
            lo_reg <= {sum[0], lo_reg[MB_W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = {hi_reg, lo_reg};

endmodule

[hw/rtl/wtroc_sdiv.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on wtroc_pkg.
module wtroc_sdiv import wtroc_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [DR_W-1:0] rem_init,   // upper dividend bits, must be below divisor
    input  logic [DV_W-1:0] dividend,   // lower dividend bits
    input  logic [DR_W-1:0] divisor,
    output div_stat_t       stat,
    output logic [DV_W-1:0] quot
);

    localparam int CNT_W = $clog2(DV_W);

    logic             busy_reg;
    logic             done_reg;
    logic             over_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DR_W-1:0]  rem_reg;
    logic [DV_W-1:0]  dvd_reg;
    logic [DR_W-1:0]  dsr_reg;
    logic [DR_W:0]    shifted;
    logic [DR_W+1:0]  diff;
    logic             geq;
    logic             last;

    assign shifted = {rem_reg, dvd_reg[DV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign geq     = !diff[DR_W+1];
    assign last    = (cnt_reg == CNT_W'(DV_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where the dividend bits shift out
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= rem_init;
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            over_reg <= (rem_init >= divisor);
        end else if (busy_reg) begin
            rem_reg <= geq ? diff[DR_W-1:0] : shifted[DR_W-1:0];
            dvd_reg <= {dvd_reg[DV_W-2:0], geq};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.over = over_reg;
    assign quot      = dvd_reg;

endmodule

[hw/rtl/weighted_triple_ema_rate_of_change.sv]
// Weighted TRIX: three cascaded EMAs of a Q16.16 price with a per-item weight, and the
// scaled relative change of the third EMA as a saturated Q16.16 result. Depends on
// wtroc_pkg, wtroc_smul and wtroc_sdiv.
//
// One result item per input item. During the first seed_length items each EMA is the
// running mean and the result is 0 with ready_res low; afterwards every EMA moves by
// alpha = k*weight and the result is (ema3 - previous ema3) * 100000 / previous ema3, or 0
// when the previous ema3 is zero. Items are processed one at a time by a shared bit-serial
// multiplier and a shared radix-2 divider. A seeding item takes one product and one
// quotient; a smoothing item takes five products and one quotient, or four products and
// no quotient when the previous ema3 is zero and no rate term is computed. A stalled
// receiver adds its stall to the last state. A new item is taken while the previous
// result still waits in the output register. Config writes are always accepted and
// must only be issued while the block is idle; index 0 is seed_length, index 1 is
// smoothing_factor, other indexes are ignored.
module weighted_triple_ema_rate_of_change import wtroc_pkg::*; #(
    parameter int MAX_SEED_LENGTH = 4096,   // 2 .. 65536
    parameter int PRICE_FRAC_BITS = 16      // 8 .. 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,     // [31:0] price, [47:32] weight
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [RES_W-1:0]      m_tdata,     // [31:0] trix_value
    output logic [0:0]            m_tuser,     // [0] ready_res
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SEED_EXT_W = 17;
    localparam logic [SEED_EXT_W-1:0] MAX_SEED = SEED_EXT_W'(MAX_SEED_LENGTH);
    // dividend of the rate term: |diff| * 100000 * 2^PRICE_FRAC_BITS
    localparam int N_W = MP_W + PRICE_FRAC_BITS;

    // ---------------------------------------------------------------- state
    state_t state_reg, state_next;

    logic [SEED_W-1:0]  seed_len_reg;
    logic [K_W-1:0]     k_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [EMA_W-1:0]   ema1_reg, ema2_reg, ema3_reg;

    // working registers
    logic [EMA_W-1:0]    x_reg;        // price with the extra fraction bits
    logic [WEIGHT_W-1:0] w_reg;        // clamped weight
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [1:0]          idx_reg;      // which EMA is being moved
    logic [DV_W-1:0]     wide_reg;     // seed numerator
    logic [DR_W-1:0]     d_reg;        // signed difference
    logic [DR_W-1:0]     mag_reg;      // rounded step magnitude
    logic [EMA_W-1:0]    prev_reg;     // ema3 before the update
    logic                neg_reg;      // sign of the rate result
    logic [RES_W-1:0]    res_reg;
    logic                res_rdy_reg;

    // output register
    logic                m_tvalid_reg;
    logic [RES_W-1:0]    m_trix_reg;
    logic                m_rdy_reg;

    // ---------------------------------------------------------------- shared units
    logic            mul_start;
    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    mul_stat_t       mul_stat;
    logic [MP_W-1:0] mul_prod;

    logic            div_start;
    logic [DR_W-1:0] div_rem;
    logic [DV_W-1:0] div_dvd;
    logic [DR_W-1:0] div_dsr;
    div_stat_t       div_stat;
    logic [DV_W-1:0] div_quot;

    wtroc_smul u_smul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .stat    (mul_stat),
        .prod    (mul_prod)
    );

    wtroc_sdiv u_sdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .stat     (div_stat),
        .quot     (div_quot)
    );

    // ---------------------------------------------------------------- datapath terms
    logic                  s_accept;
    logic                  out_free;
    logic [COUNT_W-1:0]    count_inc;
    logic [SEED_EXT_W-1:0] seed_ext, seed_eff;
    logic                  seeding;
    logic [WEIGHT_W-1:0]   w_in;

    logic [EMA_W-1:0] ema1_mag;
    logic [DV_W-1:0]  seed_prod, seed_num, seed_mag, seed_dvd;
    logic [EMA_W-1:0] seed_q, seed_mean;

    logic [EMA_W-1:0] ema_cur, ema_tgt;
    logic [DR_W-1:0]  ema_diff, d_mag, ema_step, ema_sum;
    logic [DR_W-1:0]  roc_diff, prev_ext, prev_mag;
    logic [N_W-1:0]   roc_num;

    logic             pos_sat, neg_sat;
    logic [RES_W-1:0] roc_mag, roc_res;

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign count_inc = (count_reg < COUNT_LIMIT) ? count_reg + COUNT_W'(1) : count_reg;
    assign seed_ext  = SEED_EXT_W'(seed_len_reg);
    assign seed_eff  = (seed_ext > MAX_SEED) ? MAX_SEED : seed_ext;
    assign seeding   = (SEED_EXT_W'(count_inc) <= seed_eff);
    assign w_in      = (s_tdata[S_DATA_W-1:PRICE_W] > WEIGHT_ONE) ? WEIGHT_ONE
                                                                  : s_tdata[S_DATA_W-1:PRICE_W];

    // seed mean: (ema1*(n-1) + x + n/2) / n in sign-magnitude
    assign ema1_mag  = ema1_reg[EMA_W-1] ? (EMA_W'(0) - ema1_reg) : ema1_reg;
    assign seed_prod = ema1_reg[EMA_W-1] ? (DV_W'(0) - mul_prod[DV_W-1:0])
                                         : mul_prod[DV_W-1:0];
    assign seed_num  = seed_prod + {{(DV_W-EMA_W){x_reg[EMA_W-1]}}, x_reg};
    assign seed_mag  = wide_reg[DV_W-1] ? (DV_W'(0) - wide_reg) : wide_reg;
    assign seed_dvd  = seed_mag + DV_W'(count_reg >> 1);
    assign seed_q    = div_quot[EMA_W-1:0];
    assign seed_mean = wide_reg[DV_W-1] ? (EMA_W'(0) - seed_q) : seed_q;

    // EMA step: ema + round_half_away(alpha * (target - ema) / 2^16)
    always_comb begin
        case (idx_reg)
            2'd0: begin
                ema_cur = ema1_reg;
                ema_tgt = x_reg;
            end
            2'd1: begin
                ema_cur = ema2_reg;
                ema_tgt = ema1_reg;
            end
            default: begin
                ema_cur = ema3_reg;
                ema_tgt = ema2_reg;
            end
        endcase
    end

    assign ema_diff = {ema_tgt[EMA_W-1], ema_tgt} - {ema_cur[EMA_W-1], ema_cur};
    assign d_mag    = d_reg[DR_W-1] ? (DR_W'(0) - d_reg) : d_reg;
    assign ema_step = d_reg[DR_W-1] ? (DR_W'(0) - mag_reg) : mag_reg;
    assign ema_sum  = {ema_cur[EMA_W-1], ema_cur} + ema_step;

    // rate of change: |ema3 - prev| * 100000 * 2^PFB / |prev|
    assign roc_diff = {ema3_reg[EMA_W-1], ema3_reg} - {prev_reg[EMA_W-1], prev_reg};
    assign prev_ext = {prev_reg[EMA_W-1], prev_reg};
    assign prev_mag = prev_reg[EMA_W-1] ? (DR_W'(0) - prev_ext) : prev_ext;
    assign roc_num  = {mul_prod, {PRICE_FRAC_BITS{1'b0}}};

    // saturate the quotient to signed 32 bits
    assign pos_sat = div_stat.over || (|div_quot[DV_W-1:RES_W-1]);
    assign neg_sat = div_stat.over || (|div_quot[DV_W-1:RES_W])
                     || (div_quot[RES_W-1] && (|div_quot[RES_W-2:0]));
    always_comb begin
        if (neg_reg) begin
            roc_mag = neg_sat ? {1'b1, {(RES_W-1){1'b0}}} : div_quot[RES_W-1:0];
            roc_res = RES_W'(0) - roc_mag;
        end else begin
            roc_mag = pos_sat ? {1'b0, {(RES_W-1){1'b1}}} : div_quot[RES_W-1:0];
            roc_res = roc_mag;
        end
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_tvalid) begin
                               state_next = seeding ? ST_SEED_MUL : ST_ALPHA_MUL;
                           end
            ST_SEED_MUL:   state_next = ST_SEED_MWAIT;
            ST_SEED_MWAIT: if (mul_stat.done) begin
                               state_next = ST_SEED_SUM;
                           end
            ST_SEED_SUM:   state_next = ST_SEED_DIV;
            ST_SEED_DIV:   state_next = ST_SEED_DWAIT;
            ST_SEED_DWAIT: if (div_stat.done) begin
                               state_next = ST_OUT;
                           end
            ST_ALPHA_MUL:  state_next = ST_ALPHA_WAIT;
            ST_ALPHA_WAIT: if (mul_stat.done) begin
                               state_next = ST_EMA_DIFF;
                           end
            ST_EMA_DIFF:   state_next = ST_EMA_MUL;
            ST_EMA_MUL:    state_next = ST_EMA_WAIT;
            ST_EMA_WAIT:   if (mul_stat.done) begin
                               state_next = ST_EMA_RND;
                           end
            ST_EMA_RND:    state_next = ST_EMA_UPD;
            ST_EMA_UPD:    if (idx_reg != 2'd2) begin
                               state_next = ST_EMA_DIFF;
                           end else if (ema3_reg == '0) begin
                               state_next = ST_OUT;
                           end else begin
                               state_next = ST_ROC_DIFF;
                           end
            ST_ROC_DIFF:   state_next = ST_ROC_MUL;
            ST_ROC_MUL:    state_next = ST_ROC_MWAIT;
            ST_ROC_MWAIT:  if (mul_stat.done) begin
                               state_next = ST_ROC_DIV;
                           end
            ST_ROC_DIV:    state_next = ST_ROC_DWAIT;
            ST_ROC_DWAIT:  if (div_stat.done) begin
                               state_next = ST_OUT;
                           end
            ST_OUT:        if (out_free) begin
                               state_next = ST_IDLE;
                           end
            default:       state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- FSM outputs
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_rem   = '0;
        div_dvd   = '0;
        div_dsr   = '0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_SEED_MUL: begin
                mul_start = 1'b1;
                mul_a     = MA_W'(ema1_mag);
                mul_b     = MB_W'(count_reg - COUNT_W'(1));
            end
            ST_SEED_DIV: begin
                div_start = 1'b1;
                div_dvd   = seed_dvd;
                div_dsr   = DR_W'(count_reg);
            end
            ST_ALPHA_MUL: begin
                mul_start = 1'b1;
                mul_a     = MA_W'(k_reg);
                mul_b     = MB_W'(w_reg);
            end
            ST_EMA_MUL: begin
                mul_start = 1'b1;
                mul_a     = d_mag;
                mul_b     = MB_W'(alpha_reg);
            end
            ST_ROC_MUL: begin
                mul_start = 1'b1;
                mul_a     = d_mag;
                mul_b     = SCALE_CONST;
            end
            ST_ROC_DIV: begin
                div_start = 1'b1;
                div_rem   = DR_W'(roc_num >> DV_W);
                div_dvd   = roc_num[DV_W-1:0];
                div_dsr   = prev_mag;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seed_len_reg <= SEED_RESET;
            k_reg        <= K_RESET;
            count_reg    <= '0;
            ema1_reg     <= '0;
            ema2_reg     <= '0;
            ema3_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SEED_LENGTH) begin
                    seed_len_reg <= cfg_data[SEED_W-1:0];
                end else if (cfg_index == REG_SMOOTHING) begin
                    k_reg <= cfg_data[K_W-1:0];
                end
            end

            if (s_accept) begin
                count_reg <= count_inc;
            end

            if (state_reg == ST_SEED_DWAIT && div_stat.done) begin
                ema1_reg <= seed_mean;
                ema2_reg <= seed_mean;
                ema3_reg <= seed_mean;
            end

            if (state_reg == ST_EMA_UPD) begin
                case (idx_reg)
                    2'd0:    ema1_reg <= ema_sum[EMA_W-1:0];
                    2'd1:    ema2_reg <= ema_sum[EMA_W-1:0];
                    default: ema3_reg <= ema_sum[EMA_W-1:0];
                endcase
            end

            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            x_reg <= {s_tdata[PRICE_W-1:0], {EXTRA_W{1'b0}}};
            w_reg <= w_in;
        end

        unique case (state_reg)
            ST_SEED_SUM: wide_reg <= seed_num;
            ST_SEED_DWAIT: if (div_stat.done) begin
                res_reg     <= '0;
                res_rdy_reg <= 1'b0;
            end
            ST_ALPHA_WAIT: if (mul_stat.done) begin
                alpha_reg <= ALPHA_W'((mul_prod + MP_W'(16384)) >> 15);
                idx_reg   <= 2'd0;
            end
            ST_EMA_DIFF: d_reg <= ema_diff;
            ST_EMA_RND:  mag_reg <= DR_W'((mul_prod + MP_W'(32768)) >> 16);
            ST_EMA_UPD: begin
                idx_reg <= idx_reg + 2'd1;
                if (idx_reg == 2'd2) begin
                    prev_reg    <= ema3_reg;
                    res_reg     <= '0;       // kept when the previous ema3 is zero
                    res_rdy_reg <= 1'b1;
                end
            end
            ST_ROC_DIFF: d_reg <= roc_diff;
            ST_ROC_MUL:  neg_reg <= d_reg[DR_W-1] ^ prev_reg[EMA_W-1];
            ST_ROC_DWAIT: if (div_stat.done) begin
                res_reg <= roc_res;
            end
            ST_OUT: if (out_free) begin
                m_trix_reg <= res_reg;
                m_rdy_reg  <= res_rdy_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_trix_reg;
    assign m_tuser[0] = m_rdy_reg;
    assign cfg_ready  = 1'b1;

    // ---------------------------------------------------------------- assertions
    // the multiplier is never restarted in the middle of a product
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // a quotient only completes while the FSM waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_SEED_DWAIT || state_reg == ST_ROC_DWAIT))
        else $error("divider finished outside a wait state");

    // seeding results carry a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("nonzero value while seeding");

    // the point count saturates and never goes back
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg >= $past(count_reg)))
        else $error("point count decreased");

endmodule

[bench/wtroc_trix_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for weighted_triple_ema_rate_of_change: predicts each result item from the
// accepted input items and register writes, and compares. Depends on wtroc_pkg.
module wtroc_trix_checker import wtroc_pkg::*; #(
    parameter int MAX_SEED_LENGTH = 4096,
    parameter int PRICE_FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [RES_W-1:0]      m_tdata,
    input  logic [0:0]            m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    typedef struct packed {
        logic [RES_W-1:0] trix_value;
        logic             ready_res;
    } trix_result_t;

    logic [SEED_W-1:0]       seed_len;
    logic [K_W-1:0]          k_base;
    logic signed [EMA_W-1:0] ema1, ema2, ema3;
    logic [COUNT_W-1:0]      n_points;
    trix_result_t            trix_due[$];
    trix_result_t            want, got;

    task automatic report_mismatch(input string what);
        $display("[%0t] trix check: %s", $time, what);
        mismatches++;
    endtask

    // ema + round_half_away(alpha * (tgt - ema) / 2^16)
    function automatic logic signed [EMA_W-1:0] ema_toward(
        input logic signed [EMA_W-1:0] cur,
        input logic signed [EMA_W-1:0] tgt,
        input logic [ALPHA_W-1:0]      alpha
    );
        logic signed [EMA_W:0]  d;
        logic [EMA_W:0]         dm;
        logic [EMA_W+ALPHA_W:0] step;
        d    = (EMA_W+1)'(tgt) - (EMA_W+1)'(cur);
        dm   = d[EMA_W] ? -d : d;
        step = ((EMA_W+ALPHA_W+1)'(dm) * (EMA_W+ALPHA_W+1)'(alpha)
                + (EMA_W+ALPHA_W+1)'(32768)) >> 16;
        return d[EMA_W] ? cur - step[EMA_W-1:0] : cur + step[EMA_W-1:0];
    endfunction

    // diff * 100000 * 2^frac / base, truncated toward zero, saturated to 32 bits
    function automatic logic [RES_W-1:0] scaled_change(
        input logic signed [EMA_W:0]   diff,
        input logic signed [EMA_W-1:0] base
    );
        logic [127:0] dm, bm, q;
        logic         neg;
        dm  = diff < 0 ? -128'(diff) : 128'(diff);
        bm  = base < 0 ? -128'(base) : 128'(base);
        neg = (diff < 0) != (base < 0);
        q   = ((dm * 128'(SCALE_CONST)) << PRICE_FRAC_BITS) / bm;
        if (neg) begin
            if (q > 128'h8000_0000)
                q = 128'h8000_0000;
            return RES_W'(-q);
        end
        if (q > 128'h7FFF_FFFF)
            q = 128'h7FFF_FFFF;
        return q[RES_W-1:0];
    endfunction

    task automatic advance_trix(
        input  logic [PRICE_W-1:0]  price,
        input  logic [WEIGHT_W-1:0] weight,
        output trix_result_t        res
    );
        logic signed [EMA_W-1:0] x, prev;
        logic signed [EMA_W:0]   d3;
        logic signed [79:0]      num, cur_w, x_w;
        logic [79:0]             mag, cnt_w;
        logic [WEIGHT_W-1:0]     w;
        logic [32:0]             a_full;
        logic [ALPHA_W-1:0]      alpha;
        int                      eff_seed;

        x        = {price, {EXTRA_W{1'b0}}};
        eff_seed = seed_len > MAX_SEED_LENGTH ? MAX_SEED_LENGTH : int'(seed_len);
        if (n_points < COUNT_LIMIT)
            n_points = n_points + 1'b1;

        if (int'(n_points) <= eff_seed) begin
            // running mean, ties away from zero
            cur_w = 80'(ema1);
            x_w   = 80'(x);
            cnt_w = 80'(n_points);
            num   = cur_w * $signed(cnt_w - 80'd1) + x_w;
            mag   = num < 0 ? -num : num;
            mag   = (mag + cnt_w / 2) / cnt_w;
            ema1  = num < 0 ? -mag[EMA_W-1:0] : mag[EMA_W-1:0];
            ema2  = ema1;
            ema3  = ema1;
            res   = '0;
        end else begin
            w      = weight > WEIGHT_ONE ? WEIGHT_ONE : weight;
            a_full = 33'(k_base) * 33'(w) + 33'd16384;
            alpha  = a_full[30:15];
            ema1   = ema_toward(ema1, x, alpha);
            ema2   = ema_toward(ema2, ema1, alpha);
            prev   = ema3;
            ema3   = ema_toward(ema3, ema2, alpha);
            d3     = (EMA_W+1)'(ema3) - (EMA_W+1)'(prev);
            res.trix_value = prev == 0 ? '0 : scaled_change(d3, prev);
            res.ready_res  = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_len   = SEED_RESET;
            k_base     = K_RESET;
            ema1       = '0;
            ema2       = '0;
            ema3       = '0;
            n_points   = '0;
            mismatches = 0;
            trix_due.delete();
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SEED_LENGTH: seed_len = cfg_data[SEED_W-1:0];
                    REG_SMOOTHING:   k_base   = cfg_data[K_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (trix_due.size() == 0) begin
                    report_mismatch($sformatf("result item with none due, trix_value=%h",
                                              m_tdata));
                end else begin
                    want = trix_due.pop_front();
                    if (m_tdata !== want.trix_value)
                        report_mismatch($sformatf("trix_value %h, want %h",
                                                  m_tdata, want.trix_value));
                    if (m_tuser[0] !== want.ready_res)
                        report_mismatch($sformatf("ready_res %b, want %b",
                                                  m_tuser[0], want.ready_res));
                end
            end
            if (s_tvalid && s_tready) begin
                advance_trix(s_tdata[PRICE_W-1:0], s_tdata[PRICE_W +: WEIGHT_W], got);
                trix_due.push_back(got);
            end
            pending <= trix_due.size();
        end
    end

endmodule

[bench/weighted_triple_ema_rate_of_change_tb.sv]
`timescale 1ns / 1ps
// Top of the weighted_triple_ema_rate_of_change bench: clock, reset, stimulus and verdict.
// Depends on wtroc_pkg, the block itself and wtroc_trix_checker.
module weighted_triple_ema_rate_of_change_tb;
    import wtroc_pkg::*;

    localparam int MAX_SEED     = 4096;
    localparam int FRAC_BITS    = 16;
    localparam int HOLD_CYCLES  = 2000;   // long receiver hold-off, fills the block
    localparam int DRAIN_LIMIT  = 20000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 158;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd2;   // first unmapped index

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;    // [31:0] price, [47:32] weight
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [RES_W-1:0]      m_tdata;           // [31:0] trix_value
    logic [0:0]            m_tuser;           // [0] ready_res
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int   mismatches;
    int   pending;

    // stimulus knobs
    int   send_idle_pct = 0;    // chance in 100 that the sender idles a cycle
    int   stall_pct     = 0;    // chance in 100 that the receiver stalls a cycle
    logic hold_req      = 1'b0;
    logic hold_used     = 1'b0;
    int   hold_left     = 0;
    int   sent          = 0;    // items accepted so far, tracks the block's point count
    int   price_level   = 0;    // center of the current random walk

    weighted_triple_ema_rate_of_change #(
        .MAX_SEED_LENGTH (MAX_SEED),
        .PRICE_FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wtroc_trix_checker #(
        .MAX_SEED_LENGTH (MAX_SEED),
        .PRICE_FRAC_BITS (FRAC_BITS)
    ) i_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop, several times the slowest legal run.
    initial begin
        #30_000_000;
        $display("weighted_triple_ema_rate_of_change_tb failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request. The hold
    // is counted here so the sender keeps offering items while it runs.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    // One input item. valid stays up after the handshake; the next call either
    // replaces the data or drops valid in that same step, so no item repeats.
    task automatic send_sample(input logic [PRICE_W-1:0] price,
                               input logic [WEIGHT_W-1:0] weight);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {weight, price};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // One register write; valid drops for a cycle before the next write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Block idle: every result collected. Registers are only touched after this.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic int fresh_level();
        case ($urandom_range(3))
            0:       return 0;
            1:       return $signed($urandom) >>> $urandom_range(20, 8);
            2:       return (int'($urandom_range(1000, 1)) << 16) * ($urandom_range(1) ? 1 : -1);
            default: return $urandom;
        endcase
    endfunction

    // Mostly a drifting price with small noise, then wider swings, raw noise
    // and the field extremes.
    function automatic logic [PRICE_W-1:0] next_price();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            price_level += int'($urandom_range(8192)) - 4096;
            return price_level + int'($urandom_range(8191)) - 4096;
        end
        if (r < 75)
            return price_level + int'($urandom_range(2097152)) - 1048576;
        if (r < 90)
            return $urandom;
        case ($urandom_range(4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] next_weight();
        int r;
        r = $urandom_range(99);
        if (r < 65) return WEIGHT_W'($urandom_range(32768));
        if (r < 75) return WEIGHT_ONE;
        if (r < 85) return '0;
        return WEIGHT_W'($urandom_range(65535, 32769));    // above one, clamped by the block
    endfunction

    // Register values per phase: fixed extremes first, then a random mix.
    task automatic pick_settings(input int ph);
        logic [CFG_DATA_W-1:0] seed_val, k_val;
        logic [CFG_IDX_W-1:0]  spare;
        case (ph)
            0: begin seed_val = 16'd0;            k_val = 16'hFFFF;  end
            1: begin seed_val = 16'(sent + 40);   k_val = 16'd0;     end  // reseed from here
            2: begin seed_val = 16'hFFFF;         k_val = 16'd1;     end  // clamped seed
            3: begin seed_val = 16'd1;            k_val = 16'd32768; end
            default: begin
                case ($urandom_range(3))
                    0:       seed_val = 16'd0;
                    1:       seed_val = CFG_DATA_W'($urandom_range(16, 1));
                    2:       seed_val = 16'(sent + int'($urandom_range(80, 2)));
                    default: seed_val = CFG_DATA_W'($urandom_range(16'hFFFF));
                endcase
                case ($urandom_range(2))
                    0:       k_val = CFG_DATA_W'($urandom_range(16'hFFFF));
                    1:       k_val = CFG_DATA_W'($urandom_range(20000, 500));
                    default: k_val = 16'hFFFF;
                endcase
            end
        endcase
        write_reg(REG_SEED_LENGTH, seed_val);
        write_reg(REG_SMOOTHING, k_val);
        if ($urandom_range(2) == 0) begin
            spare = CFG_IDX_W'($urandom_range({CFG_IDX_W{1'b1}}, REG_SPARE_FIRST));
            write_reg(spare, CFG_DATA_W'($urandom));
        end
    endtask

    initial begin
        int waited;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // ---------------- directed part ----------------
        // Seed length zero: smoothing begins with the very first item, from zero
        // EMAs, so the first result sees a zero previous ema3. k stays at reset.
        set_idling(0, 0);
        write_reg(REG_SEED_LENGTH, 16'd0);
        send_sample(32'h0000_0000, WEIGHT_ONE);
        send_sample(32'h0001_0000, WEIGHT_ONE);
        send_sample(32'h0001_0000, 16'hFFFF);         // weight above one
        send_sample(32'h7FFF_FFFF, WEIGHT_ONE);
        send_sample(32'h8000_0000, WEIGHT_ONE);
        send_sample(32'hFFFF_FFFF, 16'd0);            // zero weight, EMAs hold
        send_sample(32'h0000_0001, 16'd1);
        send_sample(32'h8000_0000, 16'd32769);

        // Full k: near-complete moves, tiny base then big jumps saturate both ways.
        settle();
        write_reg(REG_SMOOTHING, 16'hFFFF);
        send_sample(32'h0000_0001, WEIGHT_ONE);
        send_sample(32'h7FFF_FFFF, WEIGHT_ONE);
        send_sample(32'h8000_0000, WEIGHT_ONE);
        send_sample(32'h0000_0000, WEIGHT_ONE);

        // k of zero: nothing moves.
        settle();
        write_reg(REG_SMOOTHING, 16'd0);
        send_sample(32'h1234_5678, 16'd40000);

        // Oversized seed (bits above the field dropped, then clamped): back to
        // running means mid-stream. An unmapped index must be ignored.
        settle();
        write_reg(REG_SEED_LENGTH, 16'hFFFF);
        write_reg(REG_SMOOTHING, K_RESET);
        write_reg(REG_SPARE_FIRST, 16'h0003);
        send_sample(32'h7FFF_FFFF, 16'd0);
        send_sample(32'h8000_0000, 16'hFFFF);
        send_sample(32'hFFFF_8000, 16'd100);          // -0.5, rounding ties
        send_sample(32'h0000_0003, 16'd7);

        // Seed of one with the smallest nonzero k.
        settle();
        write_reg(REG_SEED_LENGTH, 16'd1);
        write_reg(REG_SMOOTHING, 16'd1);
        send_sample(32'h0100_0000, WEIGHT_ONE);
        send_sample(32'hFF00_0000, WEIGHT_ONE);

        // ---------------- random phases ----------------
        // Idling cycles through none / sender / receiver / both.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph % 4)
                0:       set_idling(0, 0);
                1:       set_idling(68, 0);
                2:       set_idling(0, 68);
                default: set_idling(35, 35);
            endcase
            pick_settings(ph);
            price_level = fresh_level();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == 10)
                    hold_req <= 1'b1;
                if ($urandom_range(49) == 0)
                    price_level = fresh_level();
                send_sample(next_price(), next_weight());
            end
        end

        // ---------------- drain and verdict ----------------
        s_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
        repeat (200) @(posedge aclk);

        if (mismatches == 0 && pending == 0)
            $display("weighted_triple_ema_rate_of_change_tb passed");
        else
            $display("weighted_triple_ema_rate_of_change_tb failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/wtroc_pkg.sv
hw/rtl/wtroc_smul.sv
hw/rtl/wtroc_sdiv.sv
hw/rtl/weighted_triple_ema_rate_of_change.sv
bench/wtroc_trix_checker.sv
bench/weighted_triple_ema_rate_of_change_tb.sv
